[hdl/mbe_pkg.sv]
// ----------------------------------------------------------------------------
// mbe_pkg: shared types and constants of the escape-time unit
// Field widths, register indexes, controller/datapath command and status
// groups, and the span-constant helper used at elaboration.
// ----------------------------------------------------------------------------
package mbe_pkg;

  // fixed field widths
  localparam int IDX_W      = 12;
  localparam int DIM_W      = 13;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 2'd2;

  // register reset values
  localparam logic [DIM_W-1:0] WIDTH_RST    = 13'd1500;
  localparam logic [DIM_W-1:0] HEIGHT_RST   = 13'd1500;
  localparam logic [CNT_W-1:0] MAX_ITER_RST = 16'd1000;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic div_start;
    logic set_c;
    logic mul;
    logic sum;
    logic upd;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic escaped;
    logic last;
    logic limit_zero;
  } status_t;

  // round(hundredths / 100 * 2^frac), ties away from zero
  function automatic logic [63:0] scaled_const(input logic [63:0] hundredths,
                                               input int frac);
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] r;
    p = 64'd1 << frac;
    q = p / 64'd100;
    r = p % 64'd100;
    return hundredths * q + (hundredths * r + 64'd50) / 64'd100;
  endfunction

endpackage

[hdl/mbe_div.sv]
// ----------------------------------------------------------------------------
// mbe_div: restoring unsigned divider
// One quotient bit per cycle; the quotient replaces the dividend in the
// shift register and is read once done is high.
// ----------------------------------------------------------------------------
module mbe_div #(
  parameter int NB = 42,
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NB-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NB-1:0] quotient
);

  localparam int CW = $clog2(NB + 1);

  logic [CW-1:0] cnt;
  logic [NB-1:0] work;
  logic [DW-1:0] rem;
  logic [DW-1:0] dsr;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  // trial subtraction of the divisor from the shifted remainder
  always_comb begin
    trial = {rem, work[NB-1]};
    diff  = trial - {1'b0, dsr};
    fits  = trial >= {1'b0, dsr};
  end

  // bit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(NB);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  // remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (cnt != '0) begin
      work <= {work[NB-2:0], fits};
      rem  <= fits ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign done     = (cnt == '0);
  assign quotient = work;

endmodule

[hdl/mbe_datapath.sv]
// ----------------------------------------------------------------------------
// mbe_datapath: coordinate mapping and z = z^2 + c iteration
// Holds the configuration registers, two dividers for the axis mapping,
// a split-partial-product multiplier stage, a product assembly stage and
// the add/saturate/escape stage, plus the result register.
// ----------------------------------------------------------------------------
module mbe_datapath #(
  parameter int FRAC_BITS = 28,
  parameter int MAX_DIM   = 4096,
  parameter int ITER_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [mbe_pkg::IDX_W-1:0]        column,
  input  logic [mbe_pkg::IDX_W-1:0]        row,
  input  mbe_pkg::cmd_t                    cmd,
  output mbe_pkg::status_t                 st,
  output logic [mbe_pkg::CNT_W-1:0]        iteration_count
);

  import mbe_pkg::*;

  localparam int W      = FRAC_BITS + 4;
  localparam int SPAN_W = FRAC_BITS + 2;
  localparam int NB     = SPAN_W + IDX_W;
  localparam int LO     = W / 2;
  localparam int HI     = W - LO;
  localparam int PW     = 2 * W;

  localparam logic signed [W-1:0] QMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] QMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] TWO     = W'(2) << FRAC_BITS;
  localparam logic [W:0]   FOUR    = (W+1)'(1) << (FRAC_BITS + 2);
  localparam logic [W-1:0] OFF_RE  = W'(0) - TWO;
  localparam logic [W-1:0] OFF_IM  = W'(0) - W'(scaled_const(64'd112, FRAC_BITS));
  localparam logic [SPAN_W-1:0] SPAN_RE = SPAN_W'(scaled_const(64'd247, FRAC_BITS));
  localparam logic [SPAN_W-1:0] SPAN_IM = SPAN_W'(scaled_const(64'd224, FRAC_BITS));
  localparam logic signed [NB:0] QMAX_X   = {{(NB+1-W){1'b0}}, QMAX};
  localparam logic signed [NB:0] OFF_RE_X = {{(NB+1-W){OFF_RE[W-1]}}, OFF_RE};
  localparam logic signed [NB:0] OFF_IM_X = {{(NB+1-W){OFF_IM[W-1]}}, OFF_IM};
  localparam logic [PW-1:0] LIM_P = PW'(1) << (W - 1);
  localparam logic [CNT_W-1:0] ITER_MASK = (ITER_BITS >= CNT_W) ? {CNT_W{1'b1}} :
                                           CNT_W'((64'd1 << ITER_BITS) - 64'd1);

  // configuration registers
  logic [DIM_W-1:0] width;
  logic [DIM_W-1:0] height;
  logic [CNT_W-1:0] max_iter;
  logic [CNT_W-1:0] limit;

  // item and iteration state
  logic [IDX_W-1:0]     idx_re;
  logic [IDX_W-1:0]     idx_im;
  logic signed [W-1:0]  c_re;
  logic signed [W-1:0]  c_im;
  logic signed [W-1:0]  x;
  logic signed [W-1:0]  y;
  logic [CNT_W-1:0]     count;

  // divider links
  logic [NB-1:0]    dvd_re;
  logic [NB-1:0]    dvd_im;
  logic [DIM_W-1:0] dim_re;
  logic [DIM_W-1:0] dim_im;
  logic [NB-1:0]    q_re;
  logic [NB-1:0]    q_im;
  logic             done_re;
  logic             done_im;
  logic signed [NB:0] map_re;
  logic signed [NB:0] map_im;

  // multiplier stage
  logic [W-1:0]        mag_x;
  logic [W-1:0]        mag_y;
  logic [W-1:0]        ma [3];
  logic [W-1:0]        mb [3];
  logic [2*LO-1:0]     pp0 [3];
  logic [LO+HI-1:0]    pp1 [3];
  logic [LO+HI-1:0]    pp2 [3];
  logic [2*HI-1:0]     pp3 [3];
  logic                neg_xy;

  // product assembly stage
  logic [PW-1:0]       full [3];
  logic [PW-1:0]       mag_p [3];
  logic signed [W-1:0] prod [3];
  logic signed [W-1:0] x2;
  logic signed [W-1:0] y2;
  logic signed [W-1:0] xy;

  // update stage
  logic [W:0]            mod2;
  logic signed [W+1:0]   sum_re;
  logic signed [W+1:0]   sum_im;

  // clamp a dimension to 1 .. MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  // saturate a widened sum to the Q4 range
  function automatic logic signed [W-1:0] sat_q(input logic signed [W+1:0] v);
    logic signed [W-1:0] r;
    r = v[W-1:0];
    if (v > $signed({{2{1'b0}}, QMAX})) begin
      r = QMAX;
    end else if (v < $signed({{2{1'b1}}, QMIN})) begin
      r = QMIN;
    end
    return r;
  endfunction

  // two's complement magnitude, exact for the most negative code
  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    return v[W-1] ? (W'(0) - v) : v;
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      width    <= WIDTH_RST;
      height   <= HEIGHT_RST;
      max_iter <= MAX_ITER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:    width    <= cfg_data[DIM_W-1:0];
        REG_HEIGHT:   height   <= cfg_data[DIM_W-1:0];
        REG_MAX_ITER: max_iter <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign limit = max_iter & ITER_MASK;

  // span times index, divided by the clamped dimension
  assign dvd_re = NB'(SPAN_RE) * NB'(idx_re);
  assign dvd_im = NB'(SPAN_IM) * NB'(idx_im);
  assign dim_re = clamp_dim(width);
  assign dim_im = clamp_dim(height);

  mbe_div #(.NB(NB), .DW(DIM_W)) u_div_re (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd_re),
    .divisor  (dim_re),
    .done     (done_re),
    .quotient (q_re)
  );

  mbe_div #(.NB(NB), .DW(DIM_W)) u_div_im (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd_im),
    .divisor  (dim_im),
    .done     (done_im),
    .quotient (q_im)
  );

  // offset plus quotient; never below the Q4 floor
  assign map_re = $signed({1'b0, q_re}) + OFF_RE_X;
  assign map_im = $signed({1'b0, q_im}) + OFF_IM_X;

  // operand magnitudes for x*x, y*y and x*y
  always_comb begin
    mag_x = mag(x);
    mag_y = mag(y);
    ma[0] = mag_x;
    mb[0] = mag_x;
    ma[1] = mag_y;
    mb[1] = mag_y;
    ma[2] = mag_x;
    mb[2] = mag_y;
  end

  // assemble partial products, shift out the fraction, saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      full[i]  = PW'(pp0[i]) + ((PW'(pp1[i]) + PW'(pp2[i])) << LO)
               + (PW'(pp3[i]) << (2 * LO));
      mag_p[i] = full[i] >> FRAC_BITS;
      if ((i == 2) && neg_xy) begin
        prod[i] = (mag_p[i] >= LIM_P) ? QMIN : (W'(0) - mag_p[i][W-1:0]);
      end else begin
        prod[i] = (mag_p[i] >= LIM_P) ? QMAX : mag_p[i][W-1:0];
      end
    end
  end

  // escape test and next z
  always_comb begin
    mod2   = {1'b0, x2} + {1'b0, y2};
    sum_re = (W+2)'(x2) - (W+2)'(y2) + (W+2)'(c_re);
    sum_im = {xy[W-1], xy, 1'b0} + (W+2)'(c_im);
  end

  // item capture and mapped point
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_re <= column;
      idx_im <= row;
    end
    if (cmd.set_c) begin
      c_re <= (map_re > QMAX_X) ? QMAX : map_re[W-1:0];
      c_im <= (map_im > QMAX_X) ? QMAX : map_im[W-1:0];
    end
  end

  // partial products, one register stage, and the assembled products on sum
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      for (int i = 0; i < 3; i++) begin
        pp0[i] <= ma[i][LO-1:0] * mb[i][LO-1:0];
        pp1[i] <= ma[i][LO-1:0] * mb[i][W-1:LO];
        pp2[i] <= ma[i][W-1:LO] * mb[i][LO-1:0];
        pp3[i] <= ma[i][W-1:LO] * mb[i][W-1:LO];
      end
      neg_xy <= x[W-1] ^ y[W-1];
    end
    if (cmd.sum) begin
      x2 <= prod[0];
      y2 <= prod[1];
      xy <= prod[2];
    end
  end

  // z and iteration count
  always_ff @(posedge clk) begin
    if (cmd.set_c) begin
      x     <= '0;
      y     <= '0;
      count <= '0;
    end else if (cmd.upd) begin
      x     <= sat_q(sum_re);
      y     <= sat_q(sum_im);
      count <= count + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      iteration_count <= count;
    end
  end

  // status towards the controller
  always_comb begin
    st.div_done   = done_re & done_im;
    st.escaped    = mod2 >= FOUR;
    st.last       = ({1'b0, count} + 1'b1) >= {1'b0, limit};
    st.limit_zero = (limit == '0);
  end

endmodule

[hdl/mbe_ctrl.sv]
// ----------------------------------------------------------------------------
// mbe_ctrl: sequencing of one item
// Accepts an item, runs the mapping divisions, steps the iteration through
// its multiply, sum and update states until escape or limit, then hands the
// count to the output register and its valid flag.
// ----------------------------------------------------------------------------
module mbe_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  mbe_pkg::status_t st,
  output mbe_pkg::cmd_t    cmd
);

  import mbe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DSTART,
    S_DWAIT,
    S_MUL,
    S_SUM,
    S_UPD,
    S_FINISH
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // commands from the current state
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:   cmd.accept    = in_valid;
      S_DSTART: cmd.div_start = 1'b1;
      S_DWAIT:  cmd.set_c     = st.div_done;
      S_MUL:    cmd.mul       = 1'b1;
      S_SUM:    cmd.sum       = 1'b1;
      S_UPD:    cmd.upd       = !st.escaped;
      S_FINISH: cmd.out_load  = out_free;
      default: ;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_DSTART;
        end
        S_DSTART: state <= S_DWAIT;
        S_DWAIT: begin
          if (st.div_done) state <= st.limit_zero ? S_FINISH : S_MUL;
        end
        S_MUL: state <= S_SUM;
        S_SUM: state <= S_UPD;
        S_UPD: begin
          if (st.escaped || st.last) begin
            state <= S_FINISH;
          end else begin
            state <= S_MUL;
          end
        end
        S_FINISH: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/mandelbrot_escape_time_unit.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_unit: Mandelbrot escape-time counter
// Maps a pixel (column, row) onto the complex plane in signed Q4 fixed point
// and counts iterations of z = z^2 + c until |z|^2 reaches 4 or the limit.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  column, row
//   out      output     out_valid/ out_stall iteration_count
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// Each item runs k escape checks: n + 1 when the point escapes after
// n iterations, n when it reaches the limit. The two mapping divisions run
// one quotient bit per cycle (FRAC_BITS + 14 bits), and each check passes
// through the partial-product stage, the product assembly stage and the
// add, saturate and escape stage.
// One item is in work at a time; the next is taken while a result waits.
// Reset restores width, height and max_iter and empties the output register.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_unit #(
  parameter int FRAC_BITS = 28,
  parameter int MAX_DIM   = 4096,
  parameter int ITER_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mbe_pkg::IDX_W-1:0]        column,
  input  logic [mbe_pkg::IDX_W-1:0]        row,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mbe_pkg::CNT_W-1:0]        iteration_count,
  input  logic                             cfg_we,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import mbe_pkg::*;

  cmd_t    cmd;
  status_t st;

  // sequencing
  mbe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // arithmetic and registers
  mbe_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_DIM   (MAX_DIM),
    .ITER_BITS (ITER_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .column          (column),
    .row             (row),
    .cmd             (cmd),
    .st              (st),
    .iteration_count (iteration_count)
  );

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: escape-time unit check
// Feeds pixels through the valid/stall input channel and compares every
// iteration_count with a fixed-point escape-time predictor kept in step with
// the width, height and max_iter registers. A short directed pass hits the
// index extremes, zero, oversized and exact dimensions, zero and full limits,
// an unused register index, and points that stay bounded or leave at once.
// Randomised register settings and pixels follow, with random idling on both
// sides, one long output hold-off and a drain at each register change.
// ----------------------------------------------------------------------------
module testbench;
  import mbe_pkg::*;

  localparam int     FRAC            = 28;
  localparam int     DIM_CAP         = 4096;
  localparam longint Q_HI            = (longint'(1) <<< (FRAC + 3)) - 1;
  localparam longint Q_LO            = -Q_HI - 1;
  localparam longint ESCAPE_BOUND    = longint'(4) <<< FRAC;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int     RANDOM_PHASES   = 12;
  localparam int     ITEMS_PER_PHASE = 50;
  localparam int     DEEP_PHASE      = 6;
  localparam int     IN_FRAME_PCT    = 85;
  localparam int     IDLE_PCT        = 14;
  localparam int     QUIET_FROM      = 250;
  localparam int     QUIET_TO        = 400;
  localparam int     HOLD_AT         = 100;
  localparam int     HOLD_CYCLES     = 3000;
  localparam int     WATCHDOG_CYCLES = 800000;
  localparam int     DRAIN_CYCLES    = 200;

  typedef struct packed {
    logic [IDX_W-1:0] column;
    logic [IDX_W-1:0] row;
  } pixel_t;

  typedef struct packed {
    pixel_t           pixel;
    logic [CNT_W-1:0] count;
  } escape_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [IDX_W-1:0]      column    = '0;
  logic [IDX_W-1:0]      row       = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CNT_W-1:0]      iteration_count;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // register copies used for prediction
  logic [DIM_W-1:0] width_reg    = WIDTH_RST;
  logic [DIM_W-1:0] height_reg   = HEIGHT_RST;
  logic [CNT_W-1:0] max_iter_reg = MAX_ITER_RST;

  pixel_t  pixel_queue[$];
  escape_t count_queue[$];
  pixel_t  offered;
  pixel_t  accepted_px;
  escape_t oldest;
  logic [CNT_W-1:0] predicted_count;

  int unsigned n_queued   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_checked  = 0;
  int unsigned n_errors   = 0;
  int unsigned n_bounded  = 0;
  int unsigned n_deepest  = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;
  int unsigned stuck_cycles = 0;

  mandelbrot_escape_time_unit #(
    .FRAC_BITS(FRAC),
    .MAX_DIM  (DIM_CAP),
    .ITER_BITS(CNT_W)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .column         (column),
    .row            (row),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .iteration_count(iteration_count),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // saturate to the signed Q4 range
  function automatic longint clamp_q(input longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  // product truncated toward zero, then saturated
  function automatic longint fx_mul(input longint a, input longint b);
    longint p;
    longint m;
    p = a * b;
    m = (p < 0) ? -p : p;
    m = m >>> FRAC;
    if (m > Q_HI + 1) m = Q_HI + 1;
    return clamp_q((p < 0) ? -m : m);
  endfunction

  // hundredths scaled to the fraction, rounded half up
  function automatic longint span_const(input longint hundredths);
    return ((hundredths <<< FRAC) + 50) / 100;
  endfunction

  // offset plus truncated span share, dimension clipped to 1..DIM_CAP
  function automatic longint map_pixel(input longint offset, input longint span,
                                       input logic [IDX_W-1:0] idx,
                                       input logic [DIM_W-1:0] dim);
    longint d;
    d = (dim == 0) ? longint'(1) : longint'(dim);
    if (d > DIM_CAP) d = DIM_CAP;
    return clamp_q(offset + span * longint'(idx) / d);
  endfunction

  // iterations of z = z^2 + c before |z|^2 reaches 4 or the limit
  function automatic logic [CNT_W-1:0] escape_count(input pixel_t px);
    longint      c_re;
    longint      c_im;
    longint      x;
    longint      y;
    longint      x2;
    longint      y2;
    longint      xy;
    int unsigned n;
    c_re = map_pixel(-(longint'(2) <<< FRAC), span_const(247), px.column, width_reg);
    c_im = map_pixel(-span_const(112), span_const(224), px.row, height_reg);
    x = 0;
    y = 0;
    n = 0;
    while (n < max_iter_reg) begin
      x2 = fx_mul(x, x);
      y2 = fx_mul(y, y);
      if (x2 + y2 >= ESCAPE_BOUND) break;
      xy = fx_mul(x, y);
      x  = clamp_q(x2 - y2 + c_re);
      y  = clamp_q(2 * xy + c_im);
      n++;
    end
    return CNT_W'(n);
  endfunction

  // random idling, switched off for a stretch of results
  function automatic bit take_break();
    return (n_checked < QUIET_FROM || n_checked >= QUIET_TO) &&
           ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 4))
      0: return DIM_W'($urandom_range(1, 16));
      1: return DIM_W'($urandom_range(17, DIM_CAP));
      2: return WIDTH_RST;
      3: return DIM_W'(DIM_CAP);
      default: return DIM_W'($urandom);
    endcase
  endfunction

  // pixel driver, prediction on acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        accepted_px     = {column, row};
        predicted_count = escape_count(accepted_px);
        count_queue.push_back({accepted_px, predicted_count});
        if (predicted_count == max_iter_reg) n_bounded++;
        if (predicted_count > n_deepest) n_deepest = predicted_count;
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pixel_queue.size() != 0 && !take_break()) begin
          offered = pixel_queue.pop_front();
          in_valid <= 1'b1;
          column   <= offered.column;
          row      <= offered.row;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and output stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (count_queue.size() == 0) begin
          $error("iteration_count %0d arrived with no pixel waiting", iteration_count);
          n_errors++;
        end else begin
          oldest = count_queue.pop_front();
          if (iteration_count !== oldest.count) begin
            $error("iteration_count for pixel (%0d, %0d): expected %0d, actual %0d",
                   oldest.pixel.column, oldest.pixel.row, oldest.count, iteration_count);
            n_errors++;
          end
          n_checked <= n_checked + 1;
        end
      end
      // one long hold-off so the unit fills and stalls its input
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && n_checked >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= take_break();
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == WATCHDOG_CYCLES) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_CYCLES);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic push_pixel(input int unsigned col, input int unsigned rw);
    pixel_queue.push_back({IDX_W'(col), IDX_W'(rw)});
    n_queued++;
  endtask

  // wait until every queued pixel has its result back
  task automatic wait_idle();
    while (n_accepted != n_queued || n_checked != n_queued) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_WIDTH:    width_reg    = value[DIM_W-1:0];
      REG_HEIGHT:   height_reg   = value[DIM_W-1:0];
      REG_MAX_ITER: max_iter_reg = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // stimulus
  initial begin
    int unsigned w_eff;
    int unsigned h_eff;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: corners, index equal to and beyond the dimension, two inside points
    push_pixel(0, 0);
    push_pixel(4095, 4095);
    push_pixel(750, 750);
    push_pixel(911, 750);
    push_pixel(4095, 0);
    push_pixel(0, 4095);
    push_pixel(1500, 1500);
    wait_idle();

    // zero dimensions via masked upper bits, zero limit, unused index ignored
    write_reg(REG_WIDTH, 16'hE000);
    write_reg(REG_HEIGHT, 16'h0000);
    write_reg(REG_MAX_ITER, 16'h0000);
    write_reg(REG_UNUSED, 16'hFFFF);
    push_pixel(0, 0);
    push_pixel(4095, 4095);
    push_pixel(1, 1);
    wait_idle();

    // oversized dimensions and the full iteration limit
    write_reg(REG_WIDTH, 16'hFFFF);
    write_reg(REG_HEIGHT, 16'd4097);
    write_reg(REG_MAX_ITER, 16'hFFFF);
    push_pixel(0, 0);
    push_pixel(4095, 4095);
    push_pixel(3068, 2048);
    wait_idle();

    // single-pixel frame and points beyond it
    write_reg(REG_WIDTH, 16'd1);
    write_reg(REG_HEIGHT, 16'd1);
    write_reg(REG_MAX_ITER, 16'd2);
    push_pixel(0, 0);
    push_pixel(1, 0);
    push_pixel(0, 1);
    push_pixel(4095, 4095);
    wait_idle();

    // exact maximum dimension with the smallest nonzero limit
    write_reg(REG_WIDTH, 16'(DIM_CAP));
    write_reg(REG_HEIGHT, 16'd2);
    write_reg(REG_MAX_ITER, 16'd1);
    push_pixel(2048, 1);
    push_pixel(4095, 0);

    // random settings, mostly pixels inside the frame
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 16'($urandom));
      write_reg(REG_WIDTH, {3'($urandom), pick_dim()});
      write_reg(REG_HEIGHT, {3'($urandom), pick_dim()});
      write_reg(REG_MAX_ITER, (phase == DEEP_PHASE) ? MAX_ITER_RST :
                16'($urandom_range(1, 1 << $urandom_range(1, 8))));
      w_eff = (width_reg == 0) ? 1 : (width_reg > DIM_CAP) ? DIM_CAP : width_reg;
      h_eff = (height_reg == 0) ? 1 : (height_reg > DIM_CAP) ? DIM_CAP : height_reg;
      repeat (ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < IN_FRAME_PCT)
          push_pixel($urandom_range(0, w_eff - 1), $urandom_range(0, h_eff - 1));
        else
          push_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
      end
    end

    // drain and report
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (count_queue.size() != 0) begin
      $error("%0d expected counts never arrived", count_queue.size());
      n_errors++;
    end
    $display("run: %0d pixels over 5 directed and %0d random register settings",
             n_checked, RANDOM_PHASES);
    $display("run: %0d pixels reached the limit, %0d escaped, deepest count %0d",
             n_bounded, n_checked - n_bounded, n_deepest);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/mbe_pkg.sv
hdl/mbe_div.sv
hdl/mbe_datapath.sv
hdl/mbe_ctrl.sv
hdl/mandelbrot_escape_time_unit.sv
bench/testbench.sv
